@@ hw/rtl/rfo_pkg.sv @@
// rfo_pkg: shared types and constants for the ring FIFO with overwrite.
// No dependencies. Used by rfo_core and ring_fifo_with_overwrite_top.
`default_nettype none

package rfo_pkg;

	localparam int DEPTH = 16;
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		FN_SEND    = 2'd0,
		FN_SHARE   = 2'd1,
		FN_COLLECT = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [CW-1:0] fill;
		logic          ovf;
		status_t       status;
	} flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/rfo_core.sv @@
// rfo_core: queue state, slot array and the combinational step logic.
// Depends on rfo_pkg. Instantiated by ring_fifo_with_overwrite_top.
`default_nettype none

module rfo_core #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [1:0]            func,
	input  wire logic [DATA_WIDTH-1:0] data_in,
	input  wire logic                  cfg_we,
	input  wire logic [rfo_pkg::CW-1:0] cfg_wdata,
	output logic      [DATA_WIDTH-1:0] read_data,
	output logic      [DATA_WIDTH-1:0] head_data,
	output rfo_pkg::flags_t            flags
);

	localparam int DEPTH = rfo_pkg::DEPTH;
	localparam int CW = rfo_pkg::CW;
	localparam int PW = $clog2(DEPTH);
	localparam logic [CW-1:0] CAP_MAX = CW'(DEPTH);
	localparam logic [CW-1:0] CAP_RST = CW'((DEPTH < 16) ? DEPTH : 16);

	logic [DATA_WIDTH-1:0] slots_q [DEPTH];
	logic [DATA_WIDTH-1:0] head_q;
	logic [PW-1:0]         wp_q;
	logic [PW-1:0]         rd_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         cap_q;
	logic                  ovf_q;

	logic [DATA_WIDTH-1:0] head_d;
	logic [DATA_WIDTH-1:0] nxt_data;
	logic [PW-1:0]         wp_d;
	logic [PW-1:0]         rd_d;
	logic [PW-1:0]         wp_inc;
	logic [PW-1:0]         rd_inc;
	logic [CW-1:0]         fill_d;
	logic [CW-1:0]         cap_wr;
	logic                  ovf_d;
	logic                  wr_en;
	logic                  full;
	logic                  empty;
	rfo_pkg::status_t      st;

	assign full     = (fill_q == cap_q);
	assign empty    = (fill_q == '0);
	assign wp_inc   = ((CW'(wp_q) + CW'(1)) == cap_q) ? '0 : wp_q + PW'(1);
	assign rd_inc   = ((CW'(rd_q) + CW'(1)) == cap_q) ? '0 : rd_q + PW'(1);
	assign nxt_data = slots_q[rd_inc];

	always_comb begin
		priority if (cfg_wdata == '0) begin
			cap_wr = CW'(1);
		end else if (cfg_wdata > CAP_MAX) begin
			cap_wr = CAP_MAX;
		end else begin
			cap_wr = cfg_wdata;
		end
	end

	always_comb begin
		wr_en     = 1'b0;
		wp_d      = wp_q;
		rd_d      = rd_q;
		fill_d    = fill_q;
		ovf_d     = ovf_q;
		head_d    = head_q;
		read_data = '0;
		st        = rfo_pkg::ST_DONE;
		unique case (rfo_pkg::func_t'(func))
			rfo_pkg::FN_SEND: begin
				if (full) begin
					st = rfo_pkg::ST_FULL;
				end else begin
					wr_en  = 1'b1;
					wp_d   = wp_inc;
					fill_d = fill_q + CW'(1);
					ovf_d  = 1'b0;
					if (empty) begin
						head_d = data_in;
					end
				end
			end
			rfo_pkg::FN_SHARE: begin
				wr_en = 1'b1;
				wp_d  = wp_inc;
				if (full) begin
					ovf_d  = 1'b1;
					rd_d   = rd_inc;
					head_d = (rd_inc == wp_q) ? data_in : nxt_data;
				end else begin
					fill_d = fill_q + CW'(1);
					if (empty) begin
						head_d = data_in;
					end
				end
			end
			rfo_pkg::FN_COLLECT: begin
				if (empty) begin
					st = rfo_pkg::ST_EMPTY;
				end else begin
					read_data = head_q;
					fill_d    = fill_q - CW'(1);
					ovf_d     = 1'b0;
					rd_d      = rd_inc;
					head_d    = nxt_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign head_data    = (fill_d == '0) ? '0 : head_d;
	assign flags.fill   = fill_d;
	assign flags.ovf    = ovf_d;
	assign flags.status = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RST;
			wp_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cfg_we) begin
			cap_q  <= cap_wr;
			wp_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (step) begin
			wp_q   <= wp_d;
			rd_q   <= rd_d;
			fill_q <= fill_d;
			ovf_q  <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !cfg_we) begin
			head_q <= head_d;
			if (wr_en) begin
				slots_q[wp_q] <= data_in;
			end
		end
	end

`ifndef ASSERT_OFF
	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q)
		else $error("fill count exceeds capacity");

	a_ptr_align: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == cap_q) |-> (wp_q == rd_q))
		else $error("pointers misaligned at empty or full");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (fill_q == '0 && !ovf_q && wp_q == '0))
		else $error("capacity write did not empty the queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ring_fifo_with_overwrite_top.sv @@
// ring_fifo_with_overwrite_top: input register, step core, result register.
// Depends on rfo_pkg and rfo_core.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    func, data_in
//   out      out  out_valid/out_stall  read_data, head_data, fill_level,
//                                      overflowed, status
//   cfg      in   cfg_we               cfg_wdata (capacity)
//
// One item per cycle while out is not stalled; an accepted item passes the input register,
// then the result register, and the step itself is combinational logic in rfo_core.
// Reset empties the queue and sets capacity to 16 (limited to DEPTH).
// A stall on out holds the result register; the input register then holds and
// in_stall rises while it is occupied.
`default_nettype none

module ring_fifo_with_overwrite_top #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             func,
	input  wire logic [DATA_WIDTH-1:0]  data_in,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [DATA_WIDTH-1:0]  read_data,
	output logic      [DATA_WIDTH-1:0]  head_data,
	output logic      [rfo_pkg::CW-1:0] fill_level,
	output logic                        overflowed,
	output logic      [1:0]             status,
	input  wire logic                   cfg_we,
	input  wire logic [rfo_pkg::CW-1:0] cfg_wdata
);

	logic                  vld_s1;
	logic [1:0]            func_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic                  vld_s2;
	logic [DATA_WIDTH-1:0] read_data_s2;
	logic [DATA_WIDTH-1:0] head_s2;
	rfo_pkg::flags_t       flags_s2;

	logic                  s2_open;
	logic                  step;
	logic [DATA_WIDTH-1:0] core_read;
	logic [DATA_WIDTH-1:0] core_head;
	rfo_pkg::flags_t       core_flags;

	assign s2_open  = !vld_s2 || !out_stall;
	assign step     = vld_s1 && s2_open;
	assign in_stall = vld_s1 && !s2_open;

	rfo_core #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.func      (func_s1),
		.data_in   (data_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.read_data (core_read),
		.head_data (core_head),
		.flags     (core_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				vld_s1 <= in_valid;
			end
			if (s2_open) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			data_s1 <= data_in;
		end
		if (step) begin
			read_data_s2 <= core_read;
			head_s2      <= core_head;
			flags_s2     <= core_flags;
		end
	end

	assign out_valid  = vld_s2;
	assign read_data  = read_data_s2;
	assign head_data  = head_s2;
	assign fill_level = flags_s2.fill;
	assign overflowed = flags_s2.ovf;
	assign status     = flags_s2.status;

`ifndef ASSERT_OFF
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2))
		else $error("input stalled with a free stage");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (vld_s1 && $stable(func_s1) && $stable(data_s1)))
		else $error("input register lost its item while stalled");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && flags_s2.status == rfo_pkg::ST_EMPTY)
		|-> (flags_s2.fill == '0 && read_data_s2 == '0 && head_s2 == '0))
		else $error("rejected collect reported data");
`endif

endmodule

`default_nettype wire
